[rtl/lpmd_pkg.sv]
// shared types and constants for the length-prefixed message deframer
package lpmd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_LENGTH = 1'd1;

    localparam logic [7:0]  MAGIC_RESET   = 8'd0;
    localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic {
        ERR_BAD_MAGIC  = 1'b0,
        ERR_BAD_LENGTH = 1'b1
    } t_err;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_HALTED = 2'd2
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  version;
        logic [15:0] server_id;
        logic [31:0] message_length;
        logic [7:0]  body_byte;
        logic        last;
        t_err        error_code;
    } t_result;

endpackage

[rtl/lpmd_in_if.sv]
// byte input channel of the deframer
interface lpmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/lpmd_out_if.sv]
// result channel of the deframer
interface lpmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  version;
    logic [15:0] server_id;
    logic [31:0] message_length;
    logic [7:0]  body_byte;
    logic        last_of_message;
    logic        error_code;

    modport source (output valid, output result_kind, output version, output server_id,
                    output message_length, output body_byte, output last_of_message,
                    output error_code, input ready);
    modport sink   (input valid, input result_kind, input version, input server_id,
                    input message_length, input body_byte, input last_of_message,
                    input error_code, output ready);
endinterface

[rtl/lpmd_parser.sv]
// header gathering, header check and body byte counting
module lpmd_parser
    import lpmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_expected_magic,
    input  logic [31:0] i_max_len,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam logic [2:0]  POS_VERSION  = 3'd0;
    localparam logic [2:0]  POS_MAGIC    = 3'd1;
    localparam logic [2:0]  POS_SERVER_H = 3'd2;
    localparam logic [2:0]  POS_SERVER_L = 3'd3;
    localparam logic [2:0]  POS_LAST     = 3'(HEADER_BYTES - 1);
    localparam logic [31:0] HDR_LEN      = 32'(HEADER_BYTES);

    t_phase      r_phase,     n_phase;
    logic [2:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [7:0]  r_version,   n_version;
    logic [7:0]  r_magic,     n_magic;
    logic [15:0] r_server,    n_server;
    logic [31:0] r_length,    n_length;
    logic [31:0] r_remaining, n_remaining;

    logic        w_hdr_done;
    logic [31:0] w_full_len;
    logic [31:0] w_body_len;
    logic        w_magic_bad;
    logic        w_len_bad;
    logic        w_body_last;

    assign w_hdr_done  = (r_phase == PH_HEADER) && (r_hdr_cnt == POS_LAST);
    assign w_full_len  = {r_length[23:0], i_byte};
    assign w_body_len  = w_full_len - HDR_LEN;
    assign w_magic_bad = (r_magic != i_expected_magic);
    assign w_len_bad   = (w_full_len > i_max_len) || (w_full_len < HDR_LEN);
    assign w_body_last = (r_remaining <= 32'd1);

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_version   = r_version;
        n_magic     = r_magic;
        n_server    = r_server;
        n_length    = r_length;
        n_remaining = r_remaining;
        if (i_take) begin
            case (r_phase)
                PH_HEADER: begin
                    case (r_hdr_cnt)
                        POS_VERSION:  n_version = i_byte;
                        POS_MAGIC:    n_magic   = i_byte;
                        POS_SERVER_H,
                        POS_SERVER_L: n_server  = {r_server[7:0], i_byte};
                        default:      n_length  = w_full_len;
                    endcase
                    if (r_hdr_cnt != POS_LAST) begin
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end else begin
                        n_hdr_cnt = 3'd0;
                        if (w_magic_bad || w_len_bad) begin
                            n_phase = PH_HALTED;
                        end else begin
                            n_remaining = w_body_len;
                            n_phase     = (w_body_len == 32'd0) ? PH_HEADER : PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (r_remaining != 32'd0) begin
                        n_remaining = r_remaining - 32'd1;
                    end
                    if (w_body_last) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    // halted: bytes are dropped until reset
                end
            endcase
        end
    end

    // result for the item being taken
    always_comb begin
        o_res_valid          = i_take && ((r_phase == PH_BODY) || w_hdr_done);
        o_res.kind           = KIND_HEADER;
        o_res.version        = n_version;
        o_res.server_id      = n_server;
        o_res.message_length = n_length;
        o_res.body_byte      = 8'd0;
        o_res.last           = 1'b0;
        o_res.error_code     = ERR_BAD_MAGIC;
        case (r_phase)
            PH_BODY: begin
                o_res.kind      = KIND_BODY;
                o_res.body_byte = i_byte;
                o_res.last      = w_body_last;
            end
            PH_HEADER: begin
                if (w_magic_bad) begin
                    o_res.kind = KIND_ERROR;
                end else if (w_len_bad) begin
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_BAD_LENGTH;
                end else begin
                    o_res.last = (w_body_len == 32'd0);
                end
            end
            default: begin
                o_res.kind = KIND_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= 3'd0;
            r_version   <= 8'd0;
            r_magic     <= 8'd0;
            r_server    <= 16'd0;
            r_length    <= 32'd0;
            r_remaining <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_version   <= n_version;
            r_magic     <= n_magic;
            r_server    <= n_server;
            r_length    <= n_length;
            r_remaining <= n_remaining;
        end
    end

endmodule

[rtl/length_prefixed_message_deframer_unit.sv]
// top level of the length-prefixed message deframer
//
// i_in carries one raw stream byte per item. Each message opens with an
// 8-byte big-endian header: version, magic, 16-bit server, 32-bit total
// length (header included). On the eighth header byte one header item, or
// one error item, goes out on o_out; each body byte then goes out as a body
// item, the final one of the message marked by last_of_message.
// A bad magic or a length outside 8..max_message_length gives an error
// item, after which input bytes are taken and dropped until reset.
// Configuration goes through i_cfg_we / i_cfg_index / i_cfg_data:
// index 0 expected magic, index 1 maximum message length.
// A result item is registered and is valid in the cycle after its byte is taken.
// Throughput: one byte per cycle while the receiver takes results, set by the single result register.
// Reset (synchronous, active low) clears the parser to the start of a
// header, empties the result register and restores the register defaults
// (magic 0, maximum length 65536).
// When the receiver stalls with a result held, i_in.ready falls until that
// result is taken; ready stays high while the result register is empty.
module length_prefixed_message_deframer_unit
    import lpmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lpmd_in_if.sink               i_in,
    lpmd_out_if.source            o_out
);

    logic [7:0]  r_expected_magic;
    logic [31:0] r_max_len;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_take;
    logic        w_res_valid;
    t_result     w_res;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_take     = i_in.valid && i_in.ready;

    lpmd_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (w_take),
        .i_byte           (i_in.in_byte),
        .i_expected_magic (r_expected_magic),
        .i_max_len        (r_max_len),
        .o_res_valid      (w_res_valid),
        .o_res            (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= MAGIC_RESET;
            r_max_len        <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_MAGIC:     r_expected_magic <= i_cfg_data[7:0];
                CFG_MAX_MESSAGE_LENGTH: r_max_len        <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_kind     = r_out.kind;
    assign o_out.version         = r_out.version;
    assign o_out.server_id       = r_out.server_id;
    assign o_out.message_length  = r_out.message_length;
    assign o_out.body_byte       = r_out.body_byte;
    assign o_out.last_of_message = r_out.last;
    assign o_out.error_code      = r_out.error_code;

endmodule

[rtl/lpmd_checker.sv]
// port-level checks for the deframer, bound to the top level
module lpmd_checker
    import lpmd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic       i_out_last,
    input logic       i_out_error_code
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a held result stays valid and keeps its kind and last mark
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_last))
        else $error("stalled result changed");

    // an empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // error items carry no last mark, other items no error code
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == KIND_ERROR) ? !i_out_last : !i_out_error_code)
        else $error("inconsistent error fields");

    // after an error item is delivered the block goes silent
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_kind == KIND_ERROR) |=> !i_out_valid)
        else $error("result after error item");

endmodule

bind length_prefixed_message_deframer_unit lpmd_checker u_lpmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_kind       (o_out.result_kind),
    .i_out_last       (o_out.last_of_message),
    .i_out_error_code (o_out.error_code)
);

[tb/sv/lpmd_checker.sv]
// result predictor and comparator for the length-prefixed message deframer
`timescale 1ns / 1ps
module lpmd_scoreboard
    import lpmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lpmd_in_if                    i_in,
    lpmd_out_if                   i_res,
    output int                    o_fail_count,
    output int                    o_pending
);

    // own copy of the registers and the parser state
    logic [7:0]  want_magic;
    logic [31:0] len_limit;
    t_phase      parse_ph;
    logic [2:0]  hdr_cnt;
    logic [7:0]  ver_q;
    logic [7:0]  mag_q;
    logic [15:0] srv_q;
    logic [31:0] len_q;
    logic [31:0] body_left;

    t_result     expected_q[$];

    function automatic t_result make_result(input t_kind k, input logic [7:0] body,
                                            input logic last, input t_err code);
        t_result r;
        r.kind           = k;
        r.version        = ver_q;
        r.server_id      = srv_q;
        r.message_length = len_q;
        r.body_byte      = body;
        r.last           = last;
        r.error_code     = code;
        return r;
    endfunction

    function automatic void add_expected(input t_result r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    // code field is zero on header and body items
    function automatic void deframe_byte(input logic [7:0] b);
        if (parse_ph == PH_HALTED)
            return;
        if (parse_ph == PH_BODY) begin
            add_expected(make_result(KIND_BODY, b, body_left <= 32'd1, ERR_BAD_MAGIC));
            if (body_left > 32'd0)
                body_left = body_left - 32'd1;
            if (body_left == 32'd0)
                parse_ph = PH_HEADER;
            return;
        end
        case (hdr_cnt)
            3'd0: ver_q = b;
            3'd1: mag_q = b;
            3'd2, 3'd3: srv_q = {srv_q[7:0], b};
            default: len_q = {len_q[23:0], b};
        endcase
        if (hdr_cnt != 3'd7) begin
            hdr_cnt = hdr_cnt + 3'd1;
            return;
        end
        hdr_cnt = 3'd0;
        // magic is checked before the length
        if (mag_q != want_magic) begin
            add_expected(make_result(KIND_ERROR, 8'd0, 1'b0, ERR_BAD_MAGIC));
            parse_ph = PH_HALTED;
        end else if (len_q > len_limit || len_q < 32'(HEADER_BYTES)) begin
            add_expected(make_result(KIND_ERROR, 8'd0, 1'b0, ERR_BAD_LENGTH));
            parse_ph = PH_HALTED;
        end else begin
            body_left = len_q - 32'(HEADER_BYTES);
            add_expected(make_result(KIND_HEADER, 8'd0, body_left == 32'd0,
                                     ERR_BAD_MAGIC));
            parse_ph = (body_left == 32'd0) ? PH_HEADER : PH_BODY;
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    function automatic void check_result();
        t_result e;
        if (expected_q.size() == 0) begin
            $error("unexpected result item: kind %0d", i_res.result_kind);
            o_fail_count++;
            return;
        end
        e = expected_q.pop_front();
        cmp_field("result_kind", 32'(e.kind), 32'(i_res.result_kind));
        cmp_field("version", 32'(e.version), 32'(i_res.version));
        cmp_field("server_id", 32'(e.server_id), 32'(i_res.server_id));
        cmp_field("message_length", e.message_length, i_res.message_length);
        cmp_field("body_byte", 32'(e.body_byte), 32'(i_res.body_byte));
        cmp_field("last_of_message", 32'(e.last), 32'(i_res.last_of_message));
        cmp_field("error_code", 32'(e.error_code), 32'(i_res.error_code));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            want_magic   = MAGIC_RESET;
            len_limit    = MAX_LEN_RESET;
            parse_ph     = PH_HEADER;
            hdr_cnt      = 3'd0;
            ver_q        = 8'd0;
            mag_q        = 8'd0;
            srv_q        = 16'd0;
            len_q        = 32'd0;
            body_left    = 32'd0;
            o_fail_count = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_EXPECTED_MAGIC)
                    want_magic = i_cfg_data[7:0];
                else if (i_cfg_index == CFG_MAX_MESSAGE_LENGTH)
                    len_limit = i_cfg_data;
            end
            if (i_res.valid && i_res.ready)
                check_result();
            if (i_in.valid && i_in.ready)
                deframe_byte(i_in.in_byte);
        end
        o_pending = expected_q.size();
    end

endmodule

[tb/sv/tb_top.sv]
// stimulus, clocking and verdict for the length-prefixed message deframer
`timescale 1ns / 1ps
module tb_top;
    import lpmd_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef enum int {
        FAULT_MAGIC,
        FAULT_OVER,
        FAULT_UNDER,
        FAULT_TINY_LIMIT
    } t_fault;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int src_idle_pct;
    int dst_idle_pct;
    int bytes_sent;
    int frames_sent;
    int quiet_cycles;

    logic [7:0]  cur_magic;
    logic [31:0] cur_limit;
    t_fault      fault;

    lpmd_in_if  in_ch();
    lpmd_out_if out_ch();

    length_prefixed_message_deframer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    lpmd_scoreboard u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= dst_idle_pct);
    end

    // ends the run when neither channel nor the register port moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // entered and left at a falling edge
    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // sender holds off until every expected item is out, then lets the pipe settle
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx == CFG_EXPECTED_MAGIC)
            cur_magic = val[7:0];
        else
            cur_limit = val;
    endtask

    task automatic send_frame(input logic [7:0] ver, input logic [7:0] mag,
                              input logic [15:0] srv, input logic [31:0] len,
                              input int body_n, input bit alt);
        put_byte(ver);
        put_byte(mag);
        put_byte(srv[15:8]);
        put_byte(srv[7:0]);
        put_byte(len[31:24]);
        put_byte(len[23:16]);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        for (int k = 0; k < body_n; k++)
            put_byte(alt ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom));
        frames_sent++;
    endtask

    // well-formed messages with random content until the byte count reaches a target
    task automatic rand_frames(input int target);
        longint room;
        int     n;
        int     r;
        while (bytes_sent < target) begin
            room = longint'(cur_limit) - HEADER_BYTES;
            r    = $urandom_range(99);
            if (r < 70)
                n = $urandom_range(12);
            else if (r < 95)
                n = $urandom_range(64, 13);
            else
                n = $urandom_range(400, 65);
            if (n > room)
                n = int'(room);
            send_frame(8'($urandom), cur_magic, 16'($urandom), 32'(n + HEADER_BYTES), n, 1'b0);
        end
    endtask

    initial begin
        logic [31:0] bad_len;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_EXPECTED_MAGIC;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'd0;
        src_idle_pct  = 29;
        dst_idle_pct  = 55;
        bytes_sent    = 0;
        frames_sent   = 0;
        cur_magic     = MAGIC_RESET;
        cur_limit     = MAX_LEN_RESET;
        fault         = FAULT_MAGIC;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset register values: header-only message and all-ones header fields
        send_frame(8'h00, MAGIC_RESET, 16'h0000, 32'd8, 0, 1'b0);
        send_frame(8'hFF, MAGIC_RESET, 16'hFFFF, 32'd12, 4, 1'b1);
        rand_frames(300);

        // smallest legal limit: only header-only messages get through
        wait_drained();
        src_idle_pct = 55;
        dst_idle_pct = 29;
        write_reg(CFG_EXPECTED_MAGIC, 32'hFF);
        write_reg(CFG_MAX_MESSAGE_LENGTH, 32'd8);
        repeat (4) send_frame(8'($urandom), cur_magic, 16'($urandom), 32'd8, 0, 1'b0);

        // small limit so that messages often land exactly on it
        wait_drained();
        write_reg(CFG_MAX_MESSAGE_LENGTH, 32'($urandom_range(40, 9)));
        rand_frames(450);

        wait_drained();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_reg(CFG_EXPECTED_MAGIC, 32'($urandom_range(254, 1)));
        write_reg(CFG_MAX_MESSAGE_LENGTH, 32'hFFFF_FFFF);
        rand_frames(600);
        wait_drained();
        rand_frames(800);

        // one bad header closes the run, since only reset leaves the halted state
        wait_drained();
        fault = t_fault'($urandom_range(3));
        case (fault)
            FAULT_MAGIC: begin
                send_frame(8'($urandom), cur_magic ^ 8'($urandom_range(255, 1)),
                           16'($urandom), 32'($urandom), 0, 1'b0);
            end
            FAULT_OVER: begin
                write_reg(CFG_MAX_MESSAGE_LENGTH, 32'($urandom_range(1000, 8)));
                bad_len = $urandom_range(1) ? 32'hFFFF_FFFF : cur_limit + 32'd1;
                send_frame(8'($urandom), cur_magic, 16'($urandom), bad_len, 0, 1'b0);
            end
            FAULT_UNDER: begin
                send_frame(8'($urandom), cur_magic, 16'($urandom),
                           32'($urandom_range(7)), 0, 1'b0);
            end
            default: begin
                write_reg(CFG_MAX_MESSAGE_LENGTH, 32'($urandom_range(7)));
                send_frame(8'($urandom), cur_magic, 16'($urandom),
                           32'($urandom_range(64, 8)), 0, 1'b0);
            end
        endcase

        // halted: bytes and register writes must not bring anything out
        src_idle_pct = 29;
        dst_idle_pct = 55;
        repeat (24) put_byte(8'($urandom));
        wait_drained();
        write_reg(CFG_EXPECTED_MAGIC, 32'h5A);
        write_reg(CFG_MAX_MESSAGE_LENGTH, MAX_LEN_RESET);
        send_frame(8'h01, 8'h5A, 16'h1234, 32'd10, 2, 1'b0);

        wait_drained();
        repeat (5) @(negedge i_clk);
        $display("stream of %0d bytes in %0d messages under three idle mixes and several limits",
                 bytes_sent, frames_sent);
        $display("closing header fault: %s", fault.name());
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
